@@ design/wnc_pkg.sv @@
// ----------------------------------------------------------------------------
// Windowed noise covariance package
// Shared widths, register indexes, reset values and the window config type.
// ----------------------------------------------------------------------------
package wnc_pkg;

  localparam int DEFAULT_MAX_DIM     = 1024;
  localparam int DEFAULT_SAMPLE_BITS = 16;

  localparam int DIM_W       = 11;
  localparam int HALF_W      = 10;
  localparam int POS_W       = 10;
  localparam int COUNT_W     = 21;
  localparam int SCALE_W     = 32;
  localparam int OUT_W       = 32;
  localparam int CHUNK_W     = 32;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_COLS      = 3'd0,
    REG_GRID_ROWS      = 3'd1,
    REG_COL_CENTRE     = 3'd2,
    REG_ROW_CENTRE     = 3'd3,
    REG_COL_HALF_WIDTH = 3'd4,
    REG_ROW_HALF_WIDTH = 3'd5,
    REG_NORM_SCALE     = 3'd6
  } cfg_reg_e;

  localparam logic [DIM_W-1:0]   RST_GRID_COLS  = 11'd256;
  localparam logic [DIM_W-1:0]   RST_GRID_ROWS  = 11'd256;
  localparam logic [DIM_W-1:0]   RST_COL_CENTRE = 11'd128;
  localparam logic [DIM_W-1:0]   RST_ROW_CENTRE = 11'd128;
  localparam logic [HALF_W-1:0]  RST_COL_HALF   = 10'd6;
  localparam logic [HALF_W-1:0]  RST_ROW_HALF   = 10'd6;
  localparam logic [SCALE_W-1:0] RST_NORM_SCALE = 32'd0;

  typedef struct packed {
    logic [DIM_W-1:0]  grid_cols;
    logic [DIM_W-1:0]  grid_rows;
    logic [DIM_W-1:0]  col_centre;
    logic [DIM_W-1:0]  row_centre;
    logic [HALF_W-1:0] col_half_width;
    logic [HALF_W-1:0] row_half_width;
  } win_cfg_t;

endpackage

@@ design/wnc_in_if.sv @@
// ----------------------------------------------------------------------------
// Sample pair channel
// Valid/ready channel carrying one pair of complex samples and its position.
// ----------------------------------------------------------------------------
interface wnc_in_if #(
  parameter int SAMPLE_BITS = wnc_pkg::DEFAULT_SAMPLE_BITS
);
  logic                            valid;
  logic                            ready;
  logic signed [SAMPLE_BITS-1:0]   a_re;
  logic signed [SAMPLE_BITS-1:0]   a_im;
  logic signed [SAMPLE_BITS-1:0]   b_re;
  logic signed [SAMPLE_BITS-1:0]   b_im;
  logic [wnc_pkg::POS_W-1:0]       row_pos;
  logic [wnc_pkg::POS_W-1:0]       col_pos;
  logic                            last_pair;

  modport source (
    output valid, a_re, a_im, b_re, b_im, row_pos, col_pos, last_pair,
    input  ready
  );

  modport sink (
    input  valid, a_re, a_im, b_re, b_im, row_pos, col_pos, last_pair,
    output ready
  );
endinterface

@@ design/wnc_out_if.sv @@
// ----------------------------------------------------------------------------
// Covariance result channel
// Valid/ready channel carrying one scaled covariance and its pair count.
// ----------------------------------------------------------------------------
interface wnc_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [wnc_pkg::OUT_W-1:0]  cov_re;
  logic signed [wnc_pkg::OUT_W-1:0]  cov_im;
  logic [wnc_pkg::COUNT_W-1:0]       pair_count;

  modport source (
    output valid, cov_re, cov_im, pair_count,
    input  ready
  );

  modport sink (
    input  valid, cov_re, cov_im, pair_count,
    output ready
  );
endinterface

@@ design/wnc_front.sv @@
// ----------------------------------------------------------------------------
// Window classifier front end
// Reduces the window offset per axis after each config change, then runs a
// two-stage pipeline that tests each item against the window and forms the
// cross products.
// ----------------------------------------------------------------------------
module wnc_front #(
  parameter int MAX_DIM     = wnc_pkg::DEFAULT_MAX_DIM,
  parameter int SAMPLE_BITS = wnc_pkg::DEFAULT_SAMPLE_BITS,
  localparam int TermW      = 2 * SAMPLE_BITS + 1,
  localparam int EntryW     = 2 * TermW + 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  wnc_pkg::win_cfg_t cfg_i,
  input  logic              cfg_wr_i,
  wnc_in_if.sink            sample_i,
  output logic              q_valid_o,
  input  logic              q_ready_i,
  output logic [EntryW-1:0] q_data_o
);

  localparam int DimW   = wnc_pkg::DIM_W;
  localparam int HalfW  = wnc_pkg::HALF_W;
  localparam int ProdW  = 2 * SAMPLE_BITS;
  localparam int VW     = DimW + 1;
  localparam int WideW  = 2 * DimW + 1;
  localparam int RemW   = 2 * DimW + 2;
  localparam int CntW   = $clog2(DimW + 1);
  localparam int StepsB = (DimW + 1) / 2;
  localparam int NAx    = 2;

  logic [DimW-1:0]  size_raw   [NAx];
  logic [DimW-1:0]  centre_raw [NAx];
  logic [HalfW-1:0] half_raw   [NAx];
  logic [DimW-1:0]  size_eff   [NAx];
  logic [HalfW-1:0] half_eff   [NAx];
  logic [DimW-1:0]  twice_half [NAx];
  logic             full       [NAx];

  // axis 0 is rows, axis 1 is columns
  always_comb begin
    size_raw[0]   = cfg_i.grid_rows;
    size_raw[1]   = cfg_i.grid_cols;
    centre_raw[0] = cfg_i.row_centre;
    centre_raw[1] = cfg_i.col_centre;
    half_raw[0]   = cfg_i.row_half_width;
    half_raw[1]   = cfg_i.col_half_width;
    for (int ax = 0; ax < NAx; ax++) begin
      if (size_raw[ax] == '0) begin
        size_eff[ax] = DimW'(1);
      end else if (32'(size_raw[ax]) > 32'(MAX_DIM)) begin
        size_eff[ax] = DimW'(MAX_DIM);
      end else begin
        size_eff[ax] = size_raw[ax];
      end
      half_eff[ax]   = (half_raw[ax] == '0) ? HalfW'(1) : half_raw[ax];
      twice_half[ax] = DimW'({half_eff[ax], 1'b0});
      full[ax]       = (twice_half[ax] >= size_eff[ax]);
    end
  end

  // offset (half - centre) mod size, one restoring step per cycle
  logic            pre_load_q;
  logic            pre_busy_q;
  logic [CntW-1:0] pre_cnt_q;
  logic [RemW-1:0] rem_q [NAx];
  logic [RemW-1:0] div_q [NAx];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_load_q <= 1'b1;
      pre_busy_q <= 1'b1;
      pre_cnt_q  <= '0;
    end else if (cfg_wr_i) begin
      pre_load_q <= 1'b1;
      pre_busy_q <= 1'b1;
    end else if (pre_load_q) begin
      pre_load_q <= 1'b0;
      pre_cnt_q  <= CntW'(DimW);
    end else if (pre_busy_q) begin
      if (pre_cnt_q == '0) begin
        pre_busy_q <= 1'b0;
      end else begin
        pre_cnt_q <= pre_cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int ax = 0; ax < NAx; ax++) begin
      if (pre_load_q) begin
        rem_q[ax] <= (RemW'(size_eff[ax]) << DimW) + RemW'(half_eff[ax])
                     - RemW'(centre_raw[ax]);
        div_q[ax] <= RemW'(size_eff[ax]) << DimW;
      end else if (pre_busy_q) begin
        if (rem_q[ax] >= div_q[ax]) begin
          rem_q[ax] <= rem_q[ax] - div_q[ax];
        end
        div_q[ax] <= div_q[ax] >> 1;
      end
    end
  end

  // stage A: upper reduction steps and products
  logic                    va_q;
  logic [VW-1:0]           ra_q [NAx];
  logic signed [ProdW-1:0] p_q  [4];
  logic                    last_a_q;
  logic [VW-1:0]           pos_w [NAx];
  logic [WideW-1:0]        ra_w  [NAx];
  logic                    acc_in;
  logic                    move_ab;

  // stage B: lower reduction steps, window test and cross terms
  logic                    vb_q;
  logic                    hit_q;
  logic                    last_b_q;
  logic signed [TermW-1:0] re_q;
  logic signed [TermW-1:0] im_q;
  logic [WideW-1:0]        rb_w  [NAx];
  logic                    hit_ax [NAx];
  logic                    hit_w;
  logic signed [TermW-1:0] re_w;
  logic signed [TermW-1:0] im_w;

  assign move_ab        = va_q && (!vb_q || q_ready_i);
  assign sample_i.ready = !pre_busy_q && (!va_q || move_ab);
  assign acc_in         = sample_i.valid && sample_i.ready;

  always_comb begin
    pos_w[0] = VW'(sample_i.row_pos);
    pos_w[1] = VW'(sample_i.col_pos);
    for (int ax = 0; ax < NAx; ax++) begin
      ra_w[ax] = WideW'(pos_w[ax]) + WideW'(rem_q[ax][DimW-1:0]);
      for (int k = DimW; k >= StepsB; k--) begin
        if (ra_w[ax] >= (WideW'(size_eff[ax]) << k)) begin
          ra_w[ax] = ra_w[ax] - (WideW'(size_eff[ax]) << k);
        end
      end
    end
  end

  always_comb begin
    hit_w = 1'b1;
    for (int ax = 0; ax < NAx; ax++) begin
      rb_w[ax] = WideW'(ra_q[ax]);
      for (int k = StepsB - 1; k >= 0; k--) begin
        if (rb_w[ax] >= (WideW'(size_eff[ax]) << k)) begin
          rb_w[ax] = rb_w[ax] - (WideW'(size_eff[ax]) << k);
        end
      end
      hit_ax[ax] = full[ax] || (rb_w[ax][DimW-1:0] < twice_half[ax]);
      hit_w      = hit_w && hit_ax[ax];
    end
    re_w = TermW'(p_q[0]) + TermW'(p_q[1]);
    im_w = TermW'(p_q[2]) - TermW'(p_q[3]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      if (acc_in) begin
        va_q <= 1'b1;
      end else if (move_ab) begin
        va_q <= 1'b0;
      end
      if (move_ab) begin
        vb_q <= 1'b1;
      end else if (q_ready_i) begin
        vb_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_in) begin
      for (int ax = 0; ax < NAx; ax++) begin
        ra_q[ax] <= VW'(ra_w[ax]);
      end
      p_q[0]   <= ProdW'(sample_i.a_re) * ProdW'(sample_i.b_re);
      p_q[1]   <= ProdW'(sample_i.a_im) * ProdW'(sample_i.b_im);
      p_q[2]   <= ProdW'(sample_i.a_im) * ProdW'(sample_i.b_re);
      p_q[3]   <= ProdW'(sample_i.a_re) * ProdW'(sample_i.b_im);
      last_a_q <= sample_i.last_pair;
    end
    if (move_ab) begin
      hit_q    <= hit_w;
      last_b_q <= last_a_q;
      re_q     <= re_w;
      im_q     <= im_w;
    end
  end

  assign q_valid_o = vb_q;
  assign q_data_o  = {hit_q, last_b_q, re_q, im_q};

endmodule

@@ design/wnc_queue.sv @@
// ----------------------------------------------------------------------------
// Classified item queue
// Small FIFO between the classifier and the accumulator.
// ----------------------------------------------------------------------------
module wnc_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = wnc_pkg::QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  logic [WIDTH-1:0] data_i,
  output logic             valid_o,
  input  logic             ready_i,
  output logic [WIDTH-1:0] data_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q;
  logic [PtrW-1:0]  rd_ptr_q;
  logic [CntW-1:0]  cnt_q;
  logic             push;
  logic             pop;

  assign ready_o = (cnt_q != CntW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign push    = valid_i && ready_o;
  assign pop     = valid_o && ready_i;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

@@ design/wnc_back.sv @@
// ----------------------------------------------------------------------------
// Covariance accumulator back end
// Accumulates cross terms with saturation, and on a last item scales both
// sums chunk by chunk through a 32x32 multiplier each, rounds, saturates and
// loads the result register.
// ----------------------------------------------------------------------------
module wnc_back #(
  parameter int SAMPLE_BITS = wnc_pkg::DEFAULT_SAMPLE_BITS,
  localparam int TermW      = 2 * SAMPLE_BITS + 1,
  localparam int EntryW     = 2 * TermW + 2
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        q_valid_i,
  output logic                        q_ready_o,
  input  logic [EntryW-1:0]           q_data_i,
  input  logic [wnc_pkg::SCALE_W-1:0] norm_scale_i,
  wnc_out_if.source                   result_o
);

  localparam int CountW = wnc_pkg::COUNT_W;
  localparam int ChunkW = wnc_pkg::CHUNK_W;
  localparam int OutW   = wnc_pkg::OUT_W;
  localparam int SumW   = TermW + CountW;
  localparam int NChunk = (SumW + ChunkW - 1) / ChunkW;
  localparam int MagW   = NChunk * ChunkW;
  localparam int PrW    = 2 * ChunkW;
  localparam int VW     = ChunkW + 1;
  localparam int StepW  = $clog2(NChunk + 1);
  localparam int NLane  = 2;

  localparam logic [1:0] ST_ACC = 2'd0;
  localparam logic [1:0] ST_MAG = 2'd1;
  localparam logic [1:0] ST_MUL = 2'd2;
  localparam logic [1:0] ST_FIN = 2'd3;

  localparam logic signed [SumW-1:0] SumMax = {1'b0, {(SumW - 1){1'b1}}};
  localparam logic signed [SumW-1:0] SumMin = {1'b1, {(SumW - 1){1'b0}}};
  localparam logic [OutW-1:0]        OutMax = {1'b0, {(OutW - 1){1'b1}}};
  localparam logic [OutW-1:0]        OutLim = {1'b1, {(OutW - 1){1'b0}}};
  localparam logic [PrW:0]           Half   = (PrW + 1)'(1) << (ChunkW - 1);

  logic [1:0]             state_q;
  logic [StepW-1:0]       step_q;
  logic [CountW-1:0]      count_q;
  logic signed [SumW-1:0] sum_q  [NLane];
  logic [MagW-1:0]        mag_q  [NLane];
  logic [PrW-1:0]         prod_q [NLane];
  logic [VW-1:0]          v_q    [NLane];
  logic [OutW-1:0]        low_q  [NLane];
  logic                   big_q  [NLane];
  logic                   neg_q  [NLane];
  logic                   out_valid_q;
  logic [OutW-1:0]        cov_q  [NLane];
  logic [CountW-1:0]      pair_count_q;

  logic                    pop;
  logic                    take;
  logic                    hit;
  logic                    last;
  logic signed [TermW-1:0] term   [NLane];
  logic signed [SumW:0]    wide   [NLane];
  logic signed [SumW-1:0]  sum_w  [NLane];
  logic [SumW-1:0]         abs_w  [NLane];
  logic [PrW:0]            t_w    [NLane];
  logic                    big_f  [NLane];
  logic [OutW-1:0]         res_w  [NLane];
  logic                    out_free;

  assign hit       = q_data_i[EntryW-1];
  assign last      = q_data_i[EntryW-2];
  assign term[0]   = $signed(q_data_i[2*TermW-1:TermW]);
  assign term[1]   = $signed(q_data_i[TermW-1:0]);
  assign q_ready_o = (state_q == ST_ACC);
  assign pop       = q_valid_i && q_ready_o;
  assign take      = pop && hit && (count_q != wnc_pkg::COUNT_MAX);
  assign out_free  = !out_valid_q || result_o.ready;

  always_comb begin
    for (int l = 0; l < NLane; l++) begin
      wide[l] = (SumW + 1)'(sum_q[l]) + (SumW + 1)'(term[l]);
      if (wide[l][SumW] != wide[l][SumW-1]) begin
        sum_w[l] = wide[l][SumW] ? SumMin : SumMax;
      end else begin
        sum_w[l] = wide[l][SumW-1:0];
      end
      abs_w[l] = sum_q[l][SumW-1] ? SumW'(-sum_q[l]) : SumW'(sum_q[l]);
      if (step_q == StepW'(1)) begin
        t_w[l] = (PrW + 1)'(prod_q[l]) + Half;
      end else begin
        t_w[l] = (PrW + 1)'(prod_q[l]) + (PrW + 1)'(v_q[l]);
      end
      big_f[l] = big_q[l] || (v_q[l] != '0);
      if (neg_q[l]) begin
        res_w[l] = (big_f[l] || (low_q[l] > OutLim)) ? OutLim : OutW'(-low_q[l]);
      end else begin
        res_w[l] = (big_f[l] || low_q[l][OutW-1]) ? OutMax : low_q[l];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_ACC;
      step_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      for (int l = 0; l < NLane; l++) begin
        sum_q[l] <= '0;
      end
    end else begin
      if (state_q == ST_FIN && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && result_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_ACC: begin
          if (take) begin
            for (int l = 0; l < NLane; l++) begin
              sum_q[l] <= sum_w[l];
            end
            count_q <= count_q + 1'b1;
          end
          if (pop && last) begin
            state_q <= ST_MAG;
          end
        end
        ST_MAG: begin
          step_q  <= '0;
          state_q <= ST_MUL;
        end
        ST_MUL: begin
          if (step_q == StepW'(NChunk)) begin
            state_q <= ST_FIN;
          end else begin
            step_q <= step_q + 1'b1;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            count_q <= '0;
            for (int l = 0; l < NLane; l++) begin
              sum_q[l] <= '0;
            end
            state_q <= ST_ACC;
          end
        end
        default: state_q <= ST_ACC;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    for (int l = 0; l < NLane; l++) begin
      if (state_q == ST_MAG) begin
        neg_q[l] <= sum_q[l][SumW-1];
        mag_q[l] <= MagW'(abs_w[l]);
        v_q[l]   <= '0;
        big_q[l] <= 1'b0;
        low_q[l] <= '0;
      end
      if (state_q == ST_MUL) begin
        if (step_q != StepW'(NChunk)) begin
          prod_q[l] <= PrW'(mag_q[l][ChunkW-1:0]) * PrW'(norm_scale_i);
          mag_q[l]  <= mag_q[l] >> ChunkW;
        end
        if (step_q != '0) begin
          v_q[l] <= t_w[l][PrW:ChunkW];
          if (step_q == StepW'(2)) begin
            low_q[l] <= t_w[l][ChunkW-1:0];
          end else if (step_q > StepW'(2)) begin
            big_q[l] <= big_q[l] || (t_w[l][ChunkW-1:0] != '0);
          end
        end
      end
    end
    if (state_q == ST_FIN && out_free) begin
      for (int l = 0; l < NLane; l++) begin
        cov_q[l] <= res_w[l];
      end
      pair_count_q <= count_q;
    end
  end

  assign result_o.valid      = out_valid_q;
  assign result_o.cov_re     = $signed(cov_q[0]);
  assign result_o.cov_im     = $signed(cov_q[1]);
  assign result_o.pair_count = pair_count_q;

endmodule

@@ design/windowed_noise_covariance.sv @@
// ----------------------------------------------------------------------------
// Windowed noise covariance
// Sums a*conj(b) over sample pairs inside a wrapped window and emits the
// scaled, saturated sum with its pair count on each last item.
// ----------------------------------------------------------------------------
// Usage:
//   sample_i takes one pair per cycle while ready is high (valid/ready), with
//   its row, column and a last flag. result_o gives one item per last pair:
//   cov_re, cov_im and pair_count. Registers are written over
//   cfg_we_i/cfg_idx_i/cfg_data_i; the user must write them only while the
//   block is idle, and the block itself does not enforce this.
//   Throughput: one pair per cycle while ready is high; a last pair holds the
//   accumulator through the magnitude, multiply and saturate steps while one
//   32x32 multiplier per component scales the sum a chunk at a time.
//   Result path: after the last pair is accepted the result passes two
//   classifier stages, the queue, magnitude, three multiply steps and
//   saturate before it is valid.
//   After reset and after every register write, sample_i.ready stays low
//   while the window offset is reduced modulo the grid size, one bit per cycle.
//   Reset clears the sums and the count. A stalled result_o holds its item;
//   the front end and the queue keep taking pairs until the queue fills.
// ----------------------------------------------------------------------------
module windowed_noise_covariance #(
  parameter int MAX_DIM     = wnc_pkg::DEFAULT_MAX_DIM,
  parameter int SAMPLE_BITS = wnc_pkg::DEFAULT_SAMPLE_BITS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  wnc_in_if.sink                         sample_i,
  wnc_out_if.source                      result_o,
  input  logic                           cfg_we_i,
  input  logic [wnc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [wnc_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int TermW  = 2 * SAMPLE_BITS + 1;
  localparam int EntryW = 2 * TermW + 2;
  localparam int DimW   = wnc_pkg::DIM_W;
  localparam int HalfW  = wnc_pkg::HALF_W;

  wnc_pkg::win_cfg_t             win_cfg_q;
  logic [wnc_pkg::SCALE_W-1:0]   norm_scale_q;
  logic                          q_in_valid;
  logic                          q_in_ready;
  logic [EntryW-1:0]             q_in_data;
  logic                          q_out_valid;
  logic                          q_out_ready;
  logic [EntryW-1:0]             q_out_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_cfg_q.grid_cols      <= wnc_pkg::RST_GRID_COLS;
      win_cfg_q.grid_rows      <= wnc_pkg::RST_GRID_ROWS;
      win_cfg_q.col_centre     <= wnc_pkg::RST_COL_CENTRE;
      win_cfg_q.row_centre     <= wnc_pkg::RST_ROW_CENTRE;
      win_cfg_q.col_half_width <= wnc_pkg::RST_COL_HALF;
      win_cfg_q.row_half_width <= wnc_pkg::RST_ROW_HALF;
      norm_scale_q             <= wnc_pkg::RST_NORM_SCALE;
    end else if (cfg_we_i) begin
      unique case (wnc_pkg::cfg_reg_e'(cfg_idx_i))
        wnc_pkg::REG_GRID_COLS:      win_cfg_q.grid_cols      <= cfg_data_i[DimW-1:0];
        wnc_pkg::REG_GRID_ROWS:      win_cfg_q.grid_rows      <= cfg_data_i[DimW-1:0];
        wnc_pkg::REG_COL_CENTRE:     win_cfg_q.col_centre     <= cfg_data_i[DimW-1:0];
        wnc_pkg::REG_ROW_CENTRE:     win_cfg_q.row_centre     <= cfg_data_i[DimW-1:0];
        wnc_pkg::REG_COL_HALF_WIDTH: win_cfg_q.col_half_width <= cfg_data_i[HalfW-1:0];
        wnc_pkg::REG_ROW_HALF_WIDTH: win_cfg_q.row_half_width <= cfg_data_i[HalfW-1:0];
        wnc_pkg::REG_NORM_SCALE:     norm_scale_q <= cfg_data_i[wnc_pkg::SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  wnc_front #(
    .MAX_DIM     (MAX_DIM),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (win_cfg_q),
    .cfg_wr_i  (cfg_we_i),
    .sample_i  (sample_i),
    .q_valid_o (q_in_valid),
    .q_ready_i (q_in_ready),
    .q_data_o  (q_in_data)
  );

  wnc_queue #(
    .WIDTH (EntryW),
    .DEPTH (wnc_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (q_in_valid),
    .ready_o (q_in_ready),
    .data_i  (q_in_data),
    .valid_o (q_out_valid),
    .ready_i (q_out_ready),
    .data_o  (q_out_data)
  );

  wnc_back #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_out_valid),
    .q_ready_o    (q_out_ready),
    .q_data_i     (q_out_data),
    .norm_scale_i (norm_scale_q),
    .result_o     (result_o)
  );

endmodule

@@ tb/windowed_noise_covariance_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Windowed noise covariance testbench
// Streams sample pairs through a set of window settings and checks every
// covariance result against a cycle-free model of the window test, the
// saturating accumulation, the rounded Q0.32 scaling and the pair count.
// Both channels idle at random; one test holds the result side off to fill
// the block.
// ----------------------------------------------------------------------------
module windowed_noise_covariance_test;

  localparam int                          SB          = wnc_pkg::DEFAULT_SAMPLE_BITS;
  localparam int                          STALL_LIMIT = 2000;
  localparam int                          SETTLE      = 16;
  localparam int                          HOLD_LEN    = 400;
  localparam int                          RAND_PHASES = 8;
  localparam int                          PHASE_ITEMS = 175;
  localparam logic [wnc_pkg::CFG_IDX_W-1:0] REG_SPARE = 3'd7;
  localparam longint                      ACC_MAX     = 64'sh001F_FFFF_FFFF_FFFF;
  localparam longint                      ACC_MIN     = -ACC_MAX - 1;

  typedef struct packed {
    logic [SB-1:0]             a_re;
    logic [SB-1:0]             a_im;
    logic [SB-1:0]             b_re;
    logic [SB-1:0]             b_im;
    logic [wnc_pkg::POS_W-1:0] row_pos;
    logic [wnc_pkg::POS_W-1:0] col_pos;
    logic                      last_pair;
  } pair_t;

  typedef struct packed {
    logic [wnc_pkg::OUT_W-1:0]   cov_re;
    logic [wnc_pkg::OUT_W-1:0]   cov_im;
    logic [wnc_pkg::COUNT_W-1:0] pair_count;
  } cov_t;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           cfg_we_i;
  logic [wnc_pkg::CFG_IDX_W-1:0]  cfg_idx_i;
  logic [wnc_pkg::CFG_DATA_W-1:0] cfg_data_i;

  wnc_in_if  sample_if ();
  wnc_out_if result_if ();

  windowed_noise_covariance u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .sample_i   (sample_if),
    .result_o   (result_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  wnc_pkg::win_cfg_t           win_cfg;
  logic [wnc_pkg::SCALE_W-1:0] cov_scale;
  longint                      acc_re;
  longint                      acc_im;
  int unsigned                 acc_count;
  cov_t                        cov_expect_q[$];

  bit tx_idle;
  bit rx_free;
  int hold_req;
  int hold_left;
  int mismatch_count;
  int pairs_sent;
  int results_seen;
  int settings_used;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic int unsigned eff_dim(logic [wnc_pkg::DIM_W-1:0] size);
    if (size == 0) return 1;
    if (size > wnc_pkg::DEFAULT_MAX_DIM) return wnc_pkg::DEFAULT_MAX_DIM;
    return size;
  endfunction

  function automatic int unsigned eff_half(logic [wnc_pkg::HALF_W-1:0] half);
    return (half == 0) ? 1 : half;
  endfunction

  function automatic bit in_window(int unsigned pos, logic [wnc_pkg::DIM_W-1:0] size,
                                   logic [wnc_pkg::DIM_W-1:0] centre,
                                   logic [wnc_pkg::HALF_W-1:0] half);
    int unsigned sz;
    int unsigned hw;
    int unsigned d;
    sz = eff_dim(size);
    hw = eff_half(half);
    if (2 * hw >= sz) return 1'b1;
    d = (pos % sz + (sz - centre % sz) + hw % sz) % sz;
    return d < 2 * hw;
  endfunction

  function automatic longint clamp_acc(longint v);
    if (v > ACC_MAX) return ACC_MAX;
    if (v < ACC_MIN) return ACC_MIN;
    return v;
  endfunction

  function automatic logic [wnc_pkg::OUT_W-1:0] scale_sum(longint s,
                                                          logic [wnc_pkg::SCALE_W-1:0] k);
    logic [63:0] mag;
    logic [63:0] hi;
    logic [63:0] lo;
    logic [63:0] kk;
    logic [63:0] r;
    mag = (s < 0) ? 64'(-s) : 64'(s);
    hi  = mag >> 32;
    lo  = {32'd0, mag[31:0]};
    kk  = {32'd0, k};
    r   = hi * kk + ((lo * kk + 64'h8000_0000) >> 32);
    if (s < 0) begin
      if (r > 64'h8000_0000) r = 64'h8000_0000;
      r = ~r + 64'd1;
      return r[31:0];
    end
    if (r > 64'h7FFF_FFFF) r = 64'h7FFF_FFFF;
    return r[31:0];
  endfunction

  function automatic void fold_pair(pair_t p);
    longint pr;
    longint pi;
    cov_t   c;
    if (acc_count < wnc_pkg::COUNT_MAX
        && in_window(p.row_pos, win_cfg.grid_rows, win_cfg.row_centre, win_cfg.row_half_width)
        && in_window(p.col_pos, win_cfg.grid_cols, win_cfg.col_centre, win_cfg.col_half_width))
    begin
      pr = longint'($signed(p.a_re)) * longint'($signed(p.b_re))
         + longint'($signed(p.a_im)) * longint'($signed(p.b_im));
      pi = longint'($signed(p.a_im)) * longint'($signed(p.b_re))
         - longint'($signed(p.a_re)) * longint'($signed(p.b_im));
      acc_re = clamp_acc(acc_re + pr);
      acc_im = clamp_acc(acc_im + pi);
      acc_count++;
    end
    if (p.last_pair) begin
      c.cov_re     = scale_sum(acc_re, cov_scale);
      c.cov_im     = scale_sum(acc_im, cov_scale);
      c.pair_count = acc_count[wnc_pkg::COUNT_W-1:0];
      cov_expect_q.push_back(c);
      acc_re    = 0;
      acc_im    = 0;
      acc_count = 0;
    end
  endfunction

  function automatic void store_reg(logic [wnc_pkg::CFG_IDX_W-1:0] idx,
                                    logic [wnc_pkg::CFG_DATA_W-1:0] d);
    case (idx)
      wnc_pkg::REG_GRID_COLS:      win_cfg.grid_cols      = d[wnc_pkg::DIM_W-1:0];
      wnc_pkg::REG_GRID_ROWS:      win_cfg.grid_rows      = d[wnc_pkg::DIM_W-1:0];
      wnc_pkg::REG_COL_CENTRE:     win_cfg.col_centre     = d[wnc_pkg::DIM_W-1:0];
      wnc_pkg::REG_ROW_CENTRE:     win_cfg.row_centre     = d[wnc_pkg::DIM_W-1:0];
      wnc_pkg::REG_COL_HALF_WIDTH: win_cfg.col_half_width = d[wnc_pkg::HALF_W-1:0];
      wnc_pkg::REG_ROW_HALF_WIDTH: win_cfg.row_half_width = d[wnc_pkg::HALF_W-1:0];
      wnc_pkg::REG_NORM_SCALE:     cov_scale              = d;
      default: ;
    endcase
  endfunction

  function automatic pair_t mk_pair(int ar, int ai, int br, int bi, int row, int col, bit last);
    pair_t p;
    p.a_re      = SB'(ar);
    p.a_im      = SB'(ai);
    p.b_re      = SB'(br);
    p.b_im      = SB'(bi);
    p.row_pos   = wnc_pkg::POS_W'(row);
    p.col_pos   = wnc_pkg::POS_W'(col);
    p.last_pair = last;
    return p;
  endfunction

  function automatic logic [SB-1:0] pick_sample();
    case ($urandom_range(0, 39))
      0: return {1'b1, {(SB-1){1'b0}}};
      1: return {1'b0, {(SB-1){1'b1}}};
      2: return '0;
      3: return '1;
      default: return SB'($urandom());
    endcase
  endfunction

  function automatic logic [wnc_pkg::POS_W-1:0] pick_pos(logic [wnc_pkg::DIM_W-1:0] size,
                                                         logic [wnc_pkg::DIM_W-1:0] centre,
                                                         logic [wnc_pkg::HALF_W-1:0] half,
                                                         bit noise);
    int unsigned sz;
    int unsigned hw;
    int unsigned span;
    int unsigned p;
    if (noise) return wnc_pkg::POS_W'($urandom());
    sz   = eff_dim(size);
    hw   = eff_half(half);
    span = (2 * hw < sz) ? 2 * hw : sz;
    p    = (centre % sz + sz - hw % sz + $urandom_range(0, span - 1)) % sz;
    p    = p + sz * $urandom_range(0, (1023 - p) / sz);
    return wnc_pkg::POS_W'(p);
  endfunction

  function automatic pair_t rand_pair(int noise_pct, bit last);
    pair_t p;
    p.a_re      = pick_sample();
    p.a_im      = pick_sample();
    p.b_re      = pick_sample();
    p.b_im      = pick_sample();
    p.row_pos   = pick_pos(win_cfg.grid_rows, win_cfg.row_centre, win_cfg.row_half_width,
                           $urandom_range(0, 99) < noise_pct);
    p.col_pos   = pick_pos(win_cfg.grid_cols, win_cfg.col_centre, win_cfg.col_half_width,
                           $urandom_range(0, 99) < noise_pct);
    p.last_pair = last;
    return p;
  endfunction

  function automatic logic [wnc_pkg::DIM_W-1:0] pick_dim();
    case ($urandom_range(0, 11))
      0:       return 11'd1;
      1:       return 11'd1024;
      2:       return 11'd0;
      3:       return wnc_pkg::DIM_W'($urandom_range(1025, 2047));
      4:       return 11'd2;
      5, 6, 7: return wnc_pkg::DIM_W'($urandom_range(3, 64));
      default: return wnc_pkg::DIM_W'($urandom_range(65, 1024));
    endcase
  endfunction

  function automatic logic [wnc_pkg::HALF_W-1:0] pick_half(logic [wnc_pkg::DIM_W-1:0] size);
    int unsigned top;
    top = eff_dim(size) / 2;
    if (top < 1) top = 1;
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return wnc_pkg::HALF_W'($urandom_range(top, 1023));
      2:       return wnc_pkg::HALF_W'(top);
      default: return wnc_pkg::HALF_W'($urandom_range(1, top));
    endcase
  endfunction

  function automatic logic [wnc_pkg::SCALE_W-1:0] pick_scale();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return 32'h8000_0000;
      default: return $urandom() >> $urandom_range(0, 31);
    endcase
  endfunction

  function automatic wnc_pkg::win_cfg_t pick_window();
    wnc_pkg::win_cfg_t w;
    w.grid_cols      = pick_dim();
    w.grid_rows      = pick_dim();
    w.col_centre     = ($urandom_range(0, 3) == 0) ? wnc_pkg::DIM_W'($urandom()) :
                                                     wnc_pkg::DIM_W'($urandom_range(0, 1024));
    w.row_centre     = ($urandom_range(0, 3) == 0) ? wnc_pkg::DIM_W'($urandom()) :
                                                     wnc_pkg::DIM_W'($urandom_range(0, 1024));
    w.col_half_width = pick_half(w.grid_cols);
    w.row_half_width = pick_half(w.grid_rows);
    return w;
  endfunction

  function automatic wnc_pkg::win_cfg_t mk_window(int cols, int rows, int cc, int rc, int ch,
                                                  int rh);
    wnc_pkg::win_cfg_t w;
    w.grid_cols      = wnc_pkg::DIM_W'(cols);
    w.grid_rows      = wnc_pkg::DIM_W'(rows);
    w.col_centre     = wnc_pkg::DIM_W'(cc);
    w.row_centre     = wnc_pkg::DIM_W'(rc);
    w.col_half_width = wnc_pkg::HALF_W'(ch);
    w.row_half_width = wnc_pkg::HALF_W'(rh);
    return w;
  endfunction

  task automatic send_pair(input pair_t p);
    if (tx_idle) begin
      while ($urandom_range(0, 99) < 31) begin
        sample_if.valid <= 1'b0;
        @(negedge clk_i);
      end
    end
    sample_if.valid     <= 1'b1;
    sample_if.a_re      <= p.a_re;
    sample_if.a_im      <= p.a_im;
    sample_if.b_re      <= p.b_re;
    sample_if.b_im      <= p.b_im;
    sample_if.row_pos   <= p.row_pos;
    sample_if.col_pos   <= p.col_pos;
    sample_if.last_pair <= p.last_pair;
    @(posedge clk_i);
    while (!sample_if.ready) @(posedge clk_i);
    fold_pair(p);
    pairs_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_slice(input int len, input int noise_pct);
    for (int i = 0; i < len; i++) send_pair(rand_pair(noise_pct, i == len - 1));
  endtask

  // drop valid, wait out every result, then let the tail of the pipe empty
  task automatic quiesce();
    sample_if.valid <= 1'b0;
    while (cov_expect_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [wnc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [wnc_pkg::CFG_DATA_W-1:0] d);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= d;
    @(posedge clk_i);
    store_reg(idx, d);
    @(negedge clk_i);
  endtask

  task automatic apply_setting(input wnc_pkg::win_cfg_t w,
                               input logic [wnc_pkg::SCALE_W-1:0] k);
    logic [wnc_pkg::CFG_DATA_W-1:0] d;
    quiesce();
    d = $urandom(); d[wnc_pkg::DIM_W-1:0]  = w.grid_cols;
    write_reg(wnc_pkg::REG_GRID_COLS, d);
    d = $urandom(); d[wnc_pkg::DIM_W-1:0]  = w.grid_rows;
    write_reg(wnc_pkg::REG_GRID_ROWS, d);
    d = $urandom(); d[wnc_pkg::DIM_W-1:0]  = w.col_centre;
    write_reg(wnc_pkg::REG_COL_CENTRE, d);
    d = $urandom(); d[wnc_pkg::DIM_W-1:0]  = w.row_centre;
    write_reg(wnc_pkg::REG_ROW_CENTRE, d);
    d = $urandom(); d[wnc_pkg::HALF_W-1:0] = w.col_half_width;
    write_reg(wnc_pkg::REG_COL_HALF_WIDTH, d);
    d = $urandom(); d[wnc_pkg::HALF_W-1:0] = w.row_half_width;
    write_reg(wnc_pkg::REG_ROW_HALF_WIDTH, d);
    write_reg(wnc_pkg::REG_NORM_SCALE, k);
    write_reg(REG_SPARE, $urandom());
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  task automatic check_field(input string name, input longint exp_v, input longint act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
      mismatch_count++;
    end
  endtask

  always @(posedge clk_i) begin
    cov_t c;
    if (rst_ni && result_if.valid && result_if.ready) begin
      results_seen++;
      if (cov_expect_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, got re %0d im %0d count %0d", $time,
                 result_if.cov_re, result_if.cov_im, result_if.pair_count);
        mismatch_count++;
      end else begin
        c = cov_expect_q.pop_front();
        check_field("cov_re", longint'($signed(c.cov_re)), longint'(result_if.cov_re));
        check_field("cov_im", longint'($signed(c.cov_im)), longint'(result_if.cov_im));
        check_field("pair_count", longint'(c.pair_count), longint'(result_if.pair_count));
      end
    end
  end

  initial begin : rx_drive
    result_if.ready <= 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_if.ready <= 1'b0;
      end else if (rx_free) begin
        result_if.ready <= 1'b1;
      end else begin
        result_if.ready <= ($urandom_range(0, 99) >= 31);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((sample_if.valid && sample_if.ready) || (result_if.valid && result_if.ready)
          || cfg_we_i)
        quiet = 0;
      else
        quiet++;
    end
    $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
    $display("windowed_noise_covariance_test: done, errors");
    $finish;
  end

  // registers at reset values, scale zero
  task automatic test_default_window();
    send_pair(mk_pair(100, 200, 300, 400, 122, 122, 1'b0));
    send_pair(mk_pair(-5, 7, 9, -11, 133, 133, 1'b0));
    send_pair(mk_pair(1, 1, 1, 1, 121, 128, 1'b0));
    send_pair(mk_pair(1, 1, 1, 1, 128, 134, 1'b0));
    send_pair(mk_pair(32767, -32768, -32768, 32767, 1023, 0, 1'b1));
  endtask

  // full-axis window, near-unity scale, saturated outputs
  task automatic test_extremes();
    apply_setting(mk_window(1024, 1024, 1024, 1024, 512, 512), 32'hFFFF_FFFF);
    send_pair(mk_pair(-32768, -32768, -32768, -32768, 0, 1023, 1'b1));
    send_pair(mk_pair(-32768, 32767, 32767, -32768, 1023, 1023, 1'b0));
    send_pair(mk_pair(-32768, 32767, 32767, -32768, 0, 0, 1'b1));
  endtask

  // zero and oversized grid, zero half width, half-scale rounding
  task automatic test_size_limits();
    apply_setting(mk_window(0, 2047, 0, 2047, 0, 0), 32'h8000_0000);
    send_pair(mk_pair(1, 0, 1, 0, 1023, 517, 1'b0));
    send_pair(mk_pair(0, 0, 0, 0, 1022, 3, 1'b0));
    send_pair(mk_pair(3, 0, 1, 0, 0, 9, 1'b0));
    send_pair(mk_pair(0, 0, 0, 0, 1021, 9, 1'b1));
    send_pair(mk_pair(-1, -1, 1, 0, 1022, 0, 1'b1));
  endtask

  // small grid with centre and positions beyond its size
  task automatic test_small_wrap();
    apply_setting(mk_window(5, 7, 9, 20, 2, 3), 32'h4000_0000);
    send_pair(mk_pair(1000, 0, 4, 0, 1023, 1020, 1'b0));
    send_pair(mk_pair(10, 0, 1, 0, 2, 0, 1'b0));
    send_pair(mk_pair(10, 0, 1, 0, 0, 1021, 1'b0));
    send_pair(mk_pair(-2, 3, 5, 7, 1000, 4, 1'b1));
  endtask

  task automatic test_random_windows();
    int sent;
    int noise;
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      apply_setting(pick_window(), pick_scale());
      tx_idle = (ph != 3);
      rx_free = (ph == 3);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        case ($urandom_range(0, 9))
          0:       noise = 100;
          1:       noise = 50;
          default: noise = 8;
        endcase
        if ($urandom_range(0, 9) == 0) begin
          send_slice(1, noise);
          sent += 1;
        end else begin
          noise = $urandom_range(1, 24);
          send_slice(noise, 8);
          sent += noise;
        end
        if ($urandom_range(0, 19) == 0) quiesce();
      end
    end
    tx_idle = 1'b1;
    rx_free = 1'b0;
  endtask

  // stall the result side long enough to fill the block and block its input
  task automatic test_backpressure();
    apply_setting(mk_window(1, 1, 0, 0, 1, 1), pick_scale());
    tx_idle  = 1'b0;
    hold_req = HOLD_LEN;
    for (int i = 0; i < 40; i++) send_slice(2, 0);
    tx_idle = 1'b1;
    quiesce();
  endtask

  initial begin : run
    tx_idle             = 1'b1;
    rx_free             = 1'b0;
    hold_req            = 0;
    hold_left           = 0;
    mismatch_count      = 0;
    pairs_sent          = 0;
    results_seen        = 0;
    settings_used       = 1;
    rst_ni              = 1'b0;
    cfg_we_i            <= 1'b0;
    cfg_idx_i           <= '0;
    cfg_data_i          <= '0;
    sample_if.valid     <= 1'b0;
    sample_if.a_re      <= '0;
    sample_if.a_im      <= '0;
    sample_if.b_re      <= '0;
    sample_if.b_im      <= '0;
    sample_if.row_pos   <= '0;
    sample_if.col_pos   <= '0;
    sample_if.last_pair <= 1'b0;
    win_cfg   = mk_window(wnc_pkg::RST_GRID_COLS, wnc_pkg::RST_GRID_ROWS,
                          wnc_pkg::RST_COL_CENTRE, wnc_pkg::RST_ROW_CENTRE,
                          wnc_pkg::RST_COL_HALF, wnc_pkg::RST_ROW_HALF);
    cov_scale = wnc_pkg::RST_NORM_SCALE;
    acc_re    = 0;
    acc_im    = 0;
    acc_count = 0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    test_default_window();
    test_extremes();
    test_size_limits();
    test_small_wrap();
    test_random_windows();
    test_backpressure();

    quiesce();
    if (cov_expect_q.size() != 0) mismatch_count++;
    $display("%0d pairs sent, %0d results checked over %0d window settings", pairs_sent,
             results_seen, settings_used);
    $display("wrapped, full-axis and clamped windows, rounding, saturation, long stalls");
    if (mismatch_count == 0) begin
      $display("windowed_noise_covariance_test: done, clean");
    end else begin
      $display("windowed_noise_covariance_test: done, errors");
    end
    $finish;
  end

endmodule
